### src/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Shared types, constants and the color palette of the escape-time core.
// ----------------------------------------------------------------------------
package met_pkg;

  // fixed-point format of the point and of z
  localparam int FRAC_BITS    = 28;
  localparam int PALETTE_SIZE = 16;

  // field widths
  localparam int C_W   = 32;
  localparam int CNT_W = 16;
  localparam int LIM_W = 6;
  localparam int COL_W = 8;

  // |z| below 2^MAG_W (8.0) is needed for |z|^2 to stay below the largest limit
  localparam int MAG_W = FRAC_BITS + 3;
  // signed multiplier operand and full product widths
  localparam int MUL_W = MAG_W + 1;
  localparam int P_W   = 2 * MUL_W;
  // width of z after one update: |rr - ii| and |2ri| stay below 2^(FRAC_BITS+7)
  localparam int Z_W   = ((FRAC_BITS + 7 > C_W - 1) ? FRAC_BITS + 7 : C_W - 1) + 2;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT  = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] MAX_ITER_RST  = CNT_W'(2048);
  localparam logic [LIM_W-1:0] ESC_LIMIT_RST = LIM_W'(4);

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } rgb_t;

  // fixed 16-entry color table
  function automatic rgb_t palette_lookup(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{8'd70,  8'd30,  8'd10};
      4'd1:    c = '{8'd25,  8'd5,   8'd25};
      4'd2:    c = '{8'd10,  8'd0,   8'd50};
      4'd3:    c = '{8'd5,   8'd5,   8'd75};
      4'd4:    c = '{8'd0,   8'd5,   8'd100};
      4'd5:    c = '{8'd15,  8'd45,  8'd140};
      4'd6:    c = '{8'd25,  8'd85,  8'd180};
      4'd7:    c = '{8'd60,  8'd125, 8'd210};
      4'd8:    c = '{8'd135, 8'd185, 8'd230};
      4'd9:    c = '{8'd215, 8'd240, 8'd250};
      4'd10:   c = '{8'd245, 8'd235, 8'd195};
      4'd11:   c = '{8'd250, 8'd200, 8'd95};
      4'd12:   c = '{8'd255, 8'd170, 8'd0};
      4'd13:   c = '{8'd205, 8'd130, 8'd0};
      4'd14:   c = '{8'd155, 8'd90,  8'd0};
      default: c = '{8'd105, 8'd5,   8'd5};
    endcase
    return c;
  endfunction

endpackage

### src/met_if.sv
// ----------------------------------------------------------------------------
// met_if
// Valid/ready channels for point beats and result beats.
// ----------------------------------------------------------------------------
interface met_point_if
  import met_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic signed [C_W-1:0] c_real;
  logic signed [C_W-1:0] c_imag;

  modport source (output valid, c_real, c_imag, input ready);
  modport sink   (input valid, c_real, c_imag, output ready);
endinterface

interface met_result_if
  import met_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] escape_count;
  logic             in_set;
  logic [COL_W-1:0] red;
  logic [COL_W-1:0] green;
  logic [COL_W-1:0] blue;

  modport source (output valid, escape_count, in_set, red, green, blue, input ready);
  modport sink   (input valid, escape_count, in_set, red, green, blue, output ready);
endinterface

### src/mandelbrot_escape_time_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// Escape-time count and palette color for one complex point per beat.
// ----------------------------------------------------------------------------
// One point is worked at a time by a four-step sequencer around a single
// signed 32x32 multiplier: re*re, im*im, re*im, then the update of z. The
// result is loaded into the output register when a point escapes on the
// squared-magnitude test, is screened out, or reaches max_iterations and so
// lies in the set. A result beat still waiting at the output holds the load
// off. The next point beat is taken in the cycle after the load at the
// earliest. The escape test uses the exact sum of the squares; points with
// |re| or |im| at or above 8.0 escape without a multiply unless the count
// has reached max_iterations. The input is ready whenever the sequencer is
// idle, also while a finished result waits in the output register.
// Configuration must be written only while the core is idle; the core
// itself does not enforce this.
module mandelbrot_escape_time_core
  import met_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  met_point_if.sink             pt_i,
  met_result_if.source          res_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_MUL_II = 6'b000100,
    ST_MUL_RI = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] max_iter_q;
  logic [LIM_W-1:0] esc_limit_q;

  logic signed [Z_W-1:0] zr_q, zr_d, zi_q, zi_d;
  logic signed [Z_W-1:0] cr_q, ci_q;
  logic signed [P_W-1:0] p_rr_q, p_ii_q, p_ri_q;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [CNT_W-1:0]      res_count_q, res_count_d;
  logic                  res_in_set_q, res_in_set_d;

  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] out_count_q;
  logic             out_in_set_q;
  rgb_t             out_rgb_q;

  logic pt_beat;
  logic out_free;
  logic out_load;

  assign pt_beat  = pt_i.valid && pt_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign out_load = (state_q == ST_FINISH) && out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q  <= MAX_ITER_RST;
      esc_limit_q <= ESC_LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_MAX_ITER) begin
        max_iter_q <= cfg_data_i[CNT_W-1:0];
      end else if (cfg_idx_i == REG_ESC_LIMIT) begin
        esc_limit_q <= cfg_data_i[LIM_W-1:0];
      end
    end
  end

  // magnitude screen: |v| >= 8.0 escapes unless the count has reached the limit
  logic [Z_W-1:0] mag_re, mag_im;
  logic           big;

  always_comb begin
    mag_re = zr_q[Z_W-1] ? Z_W'(-zr_q) : Z_W'(zr_q);
    mag_im = zi_q[Z_W-1] ? Z_W'(-zi_q) : Z_W'(zi_q);
    big    = (|mag_re[Z_W-1:MAG_W]) || (|mag_im[Z_W-1:MAG_W]);
  end

  // shared multiplier, operands picked by step
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [P_W-1:0]   mul_p;

  always_comb begin
    mul_a = (state_q == ST_MUL_II) ? zi_q[MUL_W-1:0] : zr_q[MUL_W-1:0];
    mul_b = (state_q == ST_CHECK)  ? zr_q[MUL_W-1:0] : zi_q[MUL_W-1:0];
    mul_p = mul_a * mul_b;
  end

  // exact escape test on the registered squares
  logic [P_W:0] sq_sum;
  logic [P_W:0] esc_thr;
  logic         esc_hit;

  always_comb begin
    sq_sum  = {1'b0, p_rr_q} + {1'b0, p_ii_q};
    esc_thr = (P_W + 1)'(esc_limit_q) << (2 * FRAC_BITS);
    esc_hit = sq_sum >= esc_thr;
  end

  // z update, products floored to FRAC_BITS fraction bits
  logic signed [P_W-1:0] rr_full, ii_full, ri_full;
  logic signed [Z_W-1:0] rr_z, ii_z, ri_z, ri2_z;

  always_comb begin
    rr_full = p_rr_q >>> FRAC_BITS;
    ii_full = p_ii_q >>> FRAC_BITS;
    ri_full = p_ri_q >>> FRAC_BITS;
    rr_z    = rr_full[Z_W-1:0];
    ii_z    = ii_full[Z_W-1:0];
    ri_z    = ri_full[Z_W-1:0];
    ri2_z   = {ri_z[Z_W-2:0], 1'b0};
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    zr_d         = zr_q;
    zi_d         = zi_q;
    res_count_d  = res_count_q;
    res_in_set_d = res_in_set_q;
    case (state_q)
      ST_IDLE: begin
        if (pt_beat) begin
          zr_d    = '0;
          zi_d    = '0;
          n_d     = CNT_W'(1);
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_q >= max_iter_q) begin
          res_count_d  = max_iter_q;
          res_in_set_d = 1'b1;
          state_d      = ST_FINISH;
        end else if (big) begin
          res_count_d  = n_q;
          res_in_set_d = 1'b0;
          state_d      = ST_FINISH;
        end else begin
          state_d = ST_MUL_II;
        end
      end
      ST_MUL_II: begin
        state_d = ST_MUL_RI;
      end
      ST_MUL_RI: begin
        if (esc_hit) begin
          res_count_d  = n_q;
          res_in_set_d = 1'b0;
          state_d      = ST_FINISH;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        zr_d    = rr_z - ii_z + cr_q;
        zi_d    = ri2_z + ci_q;
        n_d     = n_q + CNT_W'(1);
        state_d = ST_CHECK;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    zr_q         <= zr_d;
    zi_q         <= zi_d;
    res_count_q  <= res_count_d;
    res_in_set_q <= res_in_set_d;
    if (pt_beat) begin
      cr_q <= {{(Z_W - C_W){pt_i.c_real[C_W-1]}}, pt_i.c_real};
      ci_q <= {{(Z_W - C_W){pt_i.c_imag[C_W-1]}}, pt_i.c_imag};
    end
    case (state_q)
      ST_CHECK:  p_rr_q <= mul_p;
      ST_MUL_II: p_ii_q <= mul_p;
      ST_MUL_RI: p_ri_q <= mul_p;
      default: begin
      end
    endcase
  end

  // output register, color picked on load
  logic [3:0] pal_idx;

  assign pal_idx = 4'(res_count_q % CNT_W'(PALETTE_SIZE));

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q  <= res_count_q;
      out_in_set_q <= res_in_set_q;
      out_rgb_q    <= res_in_set_q ? '0 : palette_lookup(pal_idx);
    end
  end

  assign pt_i.ready         = (state_q == ST_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.escape_count = out_count_q;
  assign res_o.in_set       = out_in_set_q;
  assign res_o.red          = out_rgb_q.red;
  assign res_o.green        = out_rgb_q.green;
  assign res_o.blue         = out_rgb_q.blue;

  // a point starts its first trial at count one
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_beat |=> (state_q == ST_CHECK) && (n_q == CNT_W'(1)))
    else $error("point did not start at count one");

  // every update advances the trial count by one
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (state_q == ST_CHECK) && (n_q == $past(n_q) + CNT_W'(1)))
    else $error("trial count did not advance");

  // the count never passes a limit of two or more
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> (n_q <= max_iter_q) || (max_iter_q < CNT_W'(2)))
    else $error("trial count beyond limit");

  // points in the set are black
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_in_set_q) |-> (out_rgb_q == '0))
    else $error("in-set point not black");

  // an escaped point reports a count below the limit
  a_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_in_set_q) |-> (out_count_q < max_iter_q))
    else $error("escape count not below limit");

endmodule
